// ===== sv/sme_pkg.sv =====
// Shared types and codes for the stack machine executor.
// No dependencies; sme_exec, the top level and the checker refer to it by scoped names.
package sme_pkg;

  typedef enum logic [3:0] {
    OP_NOP       = 4'd0,
    OP_END       = 4'd1,
    OP_RETURN    = 4'd2,
    OP_PRINTNUM  = 4'd3,
    OP_PRINTCHAR = 4'd4,
    OP_ENTER     = 4'd5,
    OP_JUMP      = 4'd6,
    OP_ISZERO    = 4'd7,
    OP_ADD       = 4'd8,
    OP_MUL       = 4'd9,
    OP_GETVAR    = 4'd10,
    OP_SETVAR    = 4'd11,
    OP_PUSH      = 4'd12,
    OP_POP       = 4'd13,
    OP_LOADLINE  = 4'd14
  } op_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_UNDER = 2'd1,
    ERR_OVER  = 2'd2,
    ERR_INDEX = 2'd3
  } err_t;

  // one instruction word as it arrives
  typedef struct packed {
    logic [3:0]  mode;
    logic [31:0] operand;
    logic        direct_jump;
    logic [31:0] entered_value;
    logic [15:0] line_address;
  } item_t;

  // one result word
  typedef struct packed {
    logic [15:0] next_pc;
    logic        print_valid;
    logic        print_is_char;
    logic [31:0] print_value;
    logic        halted;
    err_t        error_code;
  } res_t;

endpackage

// ===== sv/sme_exec.sv =====
// Execute logic: next machine state and result word for one instruction.
// Uses sme_pkg; top two stack entries and the entry below them come in cached.
module sme_exec #(
  parameter int STACK_DEPTH  = 64,
  parameter int VAR_COUNT    = 16,
  parameter int LINE_ENTRIES = 256,
  parameter int ADDR_BITS    = 16
) (
  input  sme_pkg::item_t         item,
  input  logic [ADDR_BITS-1:0]   pc,
  input  logic [$clog2(STACK_DEPTH+1)-1:0] count,
  input  logic [31:0]            tos,
  input  logic [31:0]            nos,
  input  logic [31:0]            below,
  input  logic [31:0]            var_rd,
  input  logic [15:0]            line_rd,
  output logic [ADDR_BITS-1:0]   pc_next,
  output logic [$clog2(STACK_DEPTH+1)-1:0] count_next,
  output logic [31:0]            tos_next,
  output logic [31:0]            nos_next,
  output logic                   stk_we,
  output logic [$clog2(STACK_DEPTH)-1:0] stk_waddr,
  output logic [31:0]            stk_wdata,
  output logic                   var_we,
  output logic [((VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1)-1:0] var_waddr,
  output logic [31:0]            var_wdata,
  output logic                   line_we,
  output logic [$clog2(LINE_ENTRIES)-1:0] line_waddr,
  output logic [15:0]            line_wdata,
  output sme_pkg::res_t          res
);

  localparam int SB = $clog2(STACK_DEPTH);
  localparam int CB = $clog2(STACK_DEPTH+1);
  localparam int VB = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;
  localparam int LB = $clog2(LINE_ENTRIES);

  logic        do_push;
  logic        do_pop;
  logic        do_arith;
  logic [31:0] push_val;
  logic [31:0] arith_val;
  logic [31:0] sum;
  logic [31:0] prod;
  logic        empty;
  logic        full;
  logic        var_oob;
  logic        line_oob;
  logic        tos_oob;

  assign sum      = tos + nos;
  assign prod     = tos * nos;
  assign empty    = (count == '0);
  assign full     = (count == CB'(STACK_DEPTH));
  assign var_oob  = (item.operand >= 32'(VAR_COUNT));
  assign line_oob = (item.operand >= 32'(LINE_ENTRIES));
  assign tos_oob  = (tos >= 32'(LINE_ENTRIES));

  assign stk_waddr  = SB'(count - CB'(2));
  assign stk_wdata  = nos;
  assign var_waddr  = VB'(item.operand);
  assign var_wdata  = tos;
  assign line_waddr = LB'(item.operand);
  assign line_wdata = item.line_address;

  always_comb begin
    pc_next    = pc + ADDR_BITS'(1);
    count_next = count;
    tos_next   = tos;
    nos_next   = nos;
    stk_we     = 1'b0;
    var_we     = 1'b0;
    line_we    = 1'b0;
    do_push    = 1'b0;
    do_pop     = 1'b0;
    do_arith   = 1'b0;
    push_val   = item.operand;
    arith_val  = sum;
    res        = '0;

    case (item.mode)
      sme_pkg::OP_END, sme_pkg::OP_RETURN: begin
        count_next = '0;
        pc_next    = pc;
        res.halted = 1'b1;
      end
      sme_pkg::OP_PRINTNUM, sme_pkg::OP_PRINTCHAR: begin
        if (empty) begin
          res.error_code = sme_pkg::ERR_UNDER;
        end else begin
          do_pop          = 1'b1;
          res.print_valid = 1'b1;
          if (item.mode == sme_pkg::OP_PRINTCHAR) begin
            res.print_is_char = 1'b1;
            res.print_value   = {24'd0, tos[7:0]};
          end else begin
            res.print_value = tos;
          end
        end
      end
      sme_pkg::OP_ENTER, sme_pkg::OP_PUSH: begin
        if (full) begin
          res.error_code = sme_pkg::ERR_OVER;
        end else begin
          do_push  = 1'b1;
          push_val = (item.mode == sme_pkg::OP_ENTER) ? item.entered_value : item.operand;
        end
      end
      sme_pkg::OP_JUMP: begin
        if (item.direct_jump) begin
          pc_next = ADDR_BITS'(item.operand);
        end else if (empty) begin
          res.error_code = sme_pkg::ERR_UNDER;
        end else if (tos_oob) begin
          res.error_code = sme_pkg::ERR_INDEX;
        end else begin
          do_pop  = 1'b1;
          pc_next = ADDR_BITS'(line_rd);
        end
      end
      sme_pkg::OP_ISZERO: begin
        if (empty) begin
          res.error_code = sme_pkg::ERR_UNDER;
        end else begin
          do_pop = 1'b1;
          if (tos == '0) begin
            pc_next = pc + ADDR_BITS'(2);
          end
        end
      end
      sme_pkg::OP_ADD, sme_pkg::OP_MUL: begin
        if (count < CB'(2)) begin
          res.error_code = sme_pkg::ERR_UNDER;
        end else begin
          do_pop    = 1'b1;
          do_arith  = 1'b1;
          arith_val = (item.mode == sme_pkg::OP_ADD) ? sum : prod;
        end
      end
      sme_pkg::OP_GETVAR: begin
        if (var_oob) begin
          res.error_code = sme_pkg::ERR_INDEX;
        end else if (full) begin
          res.error_code = sme_pkg::ERR_OVER;
        end else begin
          do_push  = 1'b1;
          push_val = var_rd;
        end
      end
      sme_pkg::OP_SETVAR: begin
        if (var_oob) begin
          res.error_code = sme_pkg::ERR_INDEX;
        end else if (empty) begin
          res.error_code = sme_pkg::ERR_UNDER;
        end else begin
          var_we = 1'b1;
        end
      end
      sme_pkg::OP_POP: begin
        if (empty) begin
          res.error_code = sme_pkg::ERR_UNDER;
        end else begin
          do_pop = 1'b1;
        end
      end
      sme_pkg::OP_LOADLINE: begin
        pc_next = pc;
        if (line_oob) begin
          res.error_code = sme_pkg::ERR_INDEX;
        end else begin
          line_we = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // push spills the old second entry to memory; pop refills it from below
    if (do_push) begin
      count_next = count + CB'(1);
      tos_next   = push_val;
      nos_next   = tos;
      stk_we     = (count >= CB'(2));
    end
    if (do_pop) begin
      count_next = count - CB'(1);
      tos_next   = do_arith ? arith_val : nos;
      nos_next   = below;
    end

    res.next_pc = 16'(pc_next);
  end

endmodule

// ===== sv/sme_store.sv =====
// Storage for the executor: spilled stack entries, variable file, line table.
// Registered reads with write-first forwarding; no package dependency.
module sme_store #(
  parameter int STACK_DEPTH  = 64,
  parameter int VAR_COUNT    = 16,
  parameter int LINE_ENTRIES = 256
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 stk_we,
  input  logic [$clog2(STACK_DEPTH)-1:0]       stk_waddr,
  input  logic [31:0]                          stk_wdata,
  input  logic [$clog2(STACK_DEPTH)-1:0]       stk_raddr,
  output logic [31:0]                          stk_rdata,
  input  logic                                 var_we,
  input  logic [((VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1)-1:0] var_waddr,
  input  logic [31:0]                          var_wdata,
  input  logic [((VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1)-1:0] var_raddr,
  output logic [31:0]                          var_rdata,
  input  logic                                 line_we,
  input  logic [$clog2(LINE_ENTRIES)-1:0]      line_waddr,
  input  logic [15:0]                          line_wdata,
  input  logic [$clog2(LINE_ENTRIES)-1:0]      line_raddr,
  output logic [15:0]                          line_rdata
);

  localparam int SB = $clog2(STACK_DEPTH);
  localparam int VB = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;
  localparam int LB = $clog2(LINE_ENTRIES);

  logic [31:0]      stk_mem  [2**SB];
  logic [31:0]      var_mem  [2**VB];
  logic [2**VB-1:0] var_vld;
  logic [15:0]      line_mem [2**LB];

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_we && (stk_waddr == stk_raddr)) begin
      stk_rdata <= stk_wdata;
    end else begin
      stk_rdata <= stk_mem[stk_raddr];
    end
  end

  // variables read as zero until first written
  always_ff @(posedge clk) begin
    if (rst) begin
      var_vld <= '0;
    end else if (var_we) begin
      var_vld[var_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (var_we) begin
      var_mem[var_waddr] <= var_wdata;
    end
    if (var_we && (var_waddr == var_raddr)) begin
      var_rdata <= var_wdata;
    end else if (var_vld[var_raddr]) begin
      var_rdata <= var_mem[var_raddr];
    end else begin
      var_rdata <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (line_we) begin
      line_mem[line_waddr] <= line_wdata;
    end
    if (line_we && (line_waddr == line_raddr)) begin
      line_rdata <= line_wdata;
    end else begin
      line_rdata <= line_mem[line_raddr];
    end
  end

endmodule

// ===== sv/stack_machine_executor_top.sv =====
// Stack machine executor: one decoded instruction per word.
// A word accepted into the input stage has its result registered once it advances.
// Throughput: one word per cycle while the output is not stalled; the top two stack
// entries are registers; the entry below, variable and line entry are read ahead.
// Reset (rst, synchronous): pc and stack count to zero, variables read as zero,
// both channel stages empty; stack spill area and line table hold no reset value.
module stack_machine_executor_top #(
  parameter int STACK_DEPTH  = 64,
  parameter int VAR_COUNT    = 16,
  parameter int LINE_ENTRIES = 256,
  parameter int ADDR_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  mode,
  input  logic [31:0] operand,
  input  logic        direct_jump,
  input  logic [31:0] entered_value,
  input  logic [15:0] line_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] next_pc,
  output logic        print_valid,
  output logic        print_is_char,
  output logic [31:0] print_value,
  output logic        halted,
  output logic [1:0]  error_code
);

  localparam int SB = $clog2(STACK_DEPTH);
  localparam int CB = $clog2(STACK_DEPTH+1);
  localparam int VB = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;
  localparam int LB = $clog2(LINE_ENTRIES);

  sme_pkg::item_t       in_q;
  logic                 in_q_valid;
  logic                 in_accept;
  logic                 advance;
  sme_pkg::res_t        res_q;
  sme_pkg::res_t        ex_res;

  logic [ADDR_BITS-1:0] pc;
  logic [CB-1:0]        count;
  logic [31:0]          tos;
  logic [31:0]          nos;
  logic [ADDR_BITS-1:0] ex_pc;
  logic [CB-1:0]        ex_count;
  logic [31:0]          ex_tos;
  logic [31:0]          ex_nos;
  logic [CB-1:0]        count_next;
  logic [31:0]          tos_next;

  logic                 stk_we;
  logic [SB-1:0]        stk_waddr;
  logic [31:0]          stk_wdata;
  logic [31:0]          below;
  logic                 var_we;
  logic [VB-1:0]        var_waddr;
  logic [31:0]          var_wdata;
  logic [31:0]          var_rd;
  logic                 line_we;
  logic [LB-1:0]        line_waddr;
  logic [15:0]          line_wdata;
  logic [15:0]          line_rd;

  assign advance   = in_q_valid && (!out_valid || !out_stall);
  assign in_stall  = in_q_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else begin
      in_q_valid <= in_accept || (in_q_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_q <= '{mode: mode, operand: operand, direct_jump: direct_jump,
                entered_value: entered_value, line_address: line_address};
    end
  end

  sme_exec #(
    .STACK_DEPTH (STACK_DEPTH),
    .VAR_COUNT   (VAR_COUNT),
    .LINE_ENTRIES(LINE_ENTRIES),
    .ADDR_BITS   (ADDR_BITS)
  ) u_exec (
    .item      (in_q),
    .pc        (pc),
    .count     (count),
    .tos       (tos),
    .nos       (nos),
    .below     (below),
    .var_rd    (var_rd),
    .line_rd   (line_rd),
    .pc_next   (ex_pc),
    .count_next(ex_count),
    .tos_next  (ex_tos),
    .nos_next  (ex_nos),
    .stk_we    (stk_we),
    .stk_waddr (stk_waddr),
    .stk_wdata (stk_wdata),
    .var_we    (var_we),
    .var_waddr (var_waddr),
    .var_wdata (var_wdata),
    .line_we   (line_we),
    .line_waddr(line_waddr),
    .line_wdata(line_wdata),
    .res       (ex_res)
  );

  assign count_next = advance ? ex_count : count;
  assign tos_next   = advance ? ex_tos : tos;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc    <= '0;
      count <= '0;
    end else if (advance) begin
      pc    <= ex_pc;
      count <= ex_count;
    end
  end

  always_ff @(posedge clk) begin
    tos <= tos_next;
    if (advance) begin
      nos <= ex_nos;
    end
  end

  // reads are addressed by the state the next word will see
  sme_store #(
    .STACK_DEPTH (STACK_DEPTH),
    .VAR_COUNT   (VAR_COUNT),
    .LINE_ENTRIES(LINE_ENTRIES)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .stk_we    (stk_we && advance),
    .stk_waddr (stk_waddr),
    .stk_wdata (stk_wdata),
    .stk_raddr (SB'(count_next - CB'(3))),
    .stk_rdata (below),
    .var_we    (var_we && advance),
    .var_waddr (var_waddr),
    .var_wdata (var_wdata),
    .var_raddr (VB'(in_accept ? operand : in_q.operand)),
    .var_rdata (var_rd),
    .line_we   (line_we && advance),
    .line_waddr(line_waddr),
    .line_wdata(line_wdata),
    .line_raddr(LB'(tos_next)),
    .line_rdata(line_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= advance || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= ex_res;
    end
  end

  assign next_pc       = res_q.next_pc;
  assign print_valid   = res_q.print_valid;
  assign print_is_char = res_q.print_is_char;
  assign print_value   = res_q.print_value;
  assign halted        = res_q.halted;
  assign error_code    = res_q.error_code;

endmodule

// ===== sv/sme_checker.sv =====
// Port-level checks for the stack machine executor, bound to the top level.
// Uses sme_pkg error codes.
module sme_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] next_pc,
  input logic        print_valid,
  input logic        print_is_char,
  input logic [31:0] print_value,
  input logic        halted,
  input logic [1:0]  error_code
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(next_pc) && $stable(print_value)
      && $stable(error_code) && $stable(halted))
    else $error("result word changed while stalled");

  a_print_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && !print_valid |-> !print_is_char && (print_value == '0))
    else $error("print fields set without a print");

  a_char_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && print_is_char |-> print_valid && (print_value[31:8] == '0))
    else $error("character print wider than a byte");

  a_halt_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && halted |-> (error_code == sme_pkg::ERR_NONE) && !print_valid)
    else $error("halt combined with error or print");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind stack_machine_executor_top sme_checker u_sme_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .next_pc      (next_pc),
  .print_valid  (print_valid),
  .print_is_char(print_is_char),
  .print_value  (print_value),
  .halted       (halted),
  .error_code   (error_code)
);
